// ----- src/lpm_pkg.sv -----
package lpm_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int PORT_BITS = 4;

   localparam int ADDR_BITS = 32;
   localparam int INDEX_BITS = 7;
   localparam int PORT_FIELD_BITS = 4;
   localparam int LEN_BITS = 6;
   localparam int INDEX_SPAN = 1 << INDEX_BITS;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] prefix;
      logic [ADDR_BITS-1:0] mask;
      logic [LEN_BITS-1:0]  len;
      logic [ADDR_BITS-1:0] hop;
      logic [PORT_BITS-1:0] port;
   } entry_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  dest;
      logic                  found;
      logic [LEN_BITS-1:0]   best_len;
      logic [INDEX_BITS-1:0] best_index;
      logic [ADDR_BITS-1:0]  hop;
      logic [PORT_BITS-1:0]  port;
   } token_type;

   function automatic logic [LEN_BITS-1:0] mask_len(input logic [ADDR_BITS-1:0] m);
      logic [2:0]          nib;
      logic [LEN_BITS-1:0] sum;
      sum = '0;
      for (int k = 0; k < ADDR_BITS / 4; k++) begin
         nib = 3'(m[4*k]) + 3'(m[4*k+1]) + 3'(m[4*k+2]) + 3'(m[4*k+3]);
         sum = sum + LEN_BITS'(nib);
      end
      return sum;
   endfunction

endpackage

// ----- src/lpm_cell.sv -----
module lpm_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lpm_pkg::INDEX_BITS-1:0]    cell_index,
   input  logic                              wr_en,
   input  logic                              wr_valid,
   input  lpm_pkg::entry_type                wr_entry,
   input  logic                              advance,
   input  logic                              up_active,
   input  lpm_pkg::token_type                up_tok,
   output logic                              dn_active,
   output lpm_pkg::token_type                dn_tok
);

   logic               valid_ff;
   lpm_pkg::entry_type entry_ff;
   logic               active_ff;
   lpm_pkg::token_type tok_ff;
   lpm_pkg::token_type tok_in;
   logic               take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_comb begin
      take = valid_ff
          && ((up_tok.dest & entry_ff.mask) == entry_ff.prefix)
          && (!up_tok.found || (entry_ff.len > up_tok.best_len));
      tok_in = up_tok;
      if (take) begin
         tok_in.found      = 1'b1;
         tok_in.best_len   = entry_ff.len;
         tok_in.best_index = cell_index;
         tok_in.hop        = entry_ff.hop;
         tok_in.port       = entry_ff.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (advance) begin
         active_ff <= up_active;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_active = active_ff;
   assign dn_tok    = tok_ff;

endmodule

// ----- src/longest_prefix_match_route_lookup_top.sv -----
// A lookup word walks the 128-cell chain one cell per clock unless the chain is
// held for a stalled result, and is then registered onto rsp_valid. No request is
// taken until that result is delivered. Writes are taken back to back while idle.
// Reset: synchronous, clears every route valid bit and the control state at
// once; route contents stay undefined until written. No clearing pass.
module longest_prefix_match_route_lookup_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [lpm_pkg::INDEX_BITS-1:0]        req_entry_index,
   input  logic                                  req_entry_valid,
   input  logic [lpm_pkg::ADDR_BITS-1:0]         req_entry_prefix,
   input  logic [lpm_pkg::ADDR_BITS-1:0]         req_entry_mask,
   input  logic [lpm_pkg::ADDR_BITS-1:0]         req_entry_gateway,
   input  logic [lpm_pkg::PORT_FIELD_BITS-1:0]   req_entry_port,
   input  logic [lpm_pkg::ADDR_BITS-1:0]         req_dest_addr,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [lpm_pkg::INDEX_BITS-1:0]        rsp_match_index,
   output logic [lpm_pkg::ADDR_BITS-1:0]         rsp_gateway,
   output logic [lpm_pkg::PORT_FIELD_BITS-1:0]   rsp_out_port
);

   lpm_pkg::state_type state_ff;
   lpm_pkg::state_type state_in;

   logic                 chain_active [0:lpm_pkg::TABLE_DEPTH];
   lpm_pkg::token_type   chain_tok    [0:lpm_pkg::TABLE_DEPTH];
   logic [lpm_pkg::TABLE_DEPTH-1:0] wr_en;

   lpm_pkg::entry_type   wr_entry;
   logic                 accept;
   logic                 write_go;
   logic                 lookup_go;
   logic                 advance;
   logic                 deliver;
   lpm_pkg::token_type   last_tok;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic                                   rsp_hit_ff;
   logic [lpm_pkg::INDEX_BITS-1:0]         rsp_match_index_ff;
   logic [lpm_pkg::ADDR_BITS-1:0]          rsp_gateway_ff;
   logic [lpm_pkg::PORT_FIELD_BITS-1:0]    rsp_out_port_ff;

   assign req_ready = (state_ff == lpm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign write_go  = accept && (req_action == lpm_pkg::ACT_WRITE);
   assign lookup_go = accept && (req_action == lpm_pkg::ACT_LOOKUP);

   assign wr_entry.prefix = req_entry_prefix;
   assign wr_entry.mask   = req_entry_mask;
   assign wr_entry.len    = lpm_pkg::mask_len(req_entry_mask);
   assign wr_entry.hop    = req_entry_gateway;
   assign wr_entry.port   = lpm_pkg::PORT_BITS'(req_entry_port);

   assign chain_active[0]        = lookup_go;
   assign chain_tok[0].dest       = req_dest_addr;
   assign chain_tok[0].found      = 1'b0;
   assign chain_tok[0].best_len   = '0;
   assign chain_tok[0].best_index = '0;
   assign chain_tok[0].hop        = '0;
   assign chain_tok[0].port       = '0;

   // hold the chain while the finished word waits for the output slot
   assign advance  = !(chain_active[lpm_pkg::TABLE_DEPTH] && rsp_valid_ff && !rsp_ready);
   assign deliver  = chain_active[lpm_pkg::TABLE_DEPTH] && advance;
   assign last_tok = chain_tok[lpm_pkg::TABLE_DEPTH];

   for (genvar i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin : g_cell
      if (i < lpm_pkg::INDEX_SPAN) begin : g_wr
         assign wr_en[i] = write_go && (req_entry_index == lpm_pkg::INDEX_BITS'(i));
      end else begin : g_nowr
         assign wr_en[i] = 1'b0;
      end

      lpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (lpm_pkg::INDEX_BITS'(i)),
         .wr_en      (wr_en[i]),
         .wr_valid   (req_entry_valid),
         .wr_entry   (wr_entry),
         .advance    (advance),
         .up_active  (chain_active[i]),
         .up_tok     (chain_tok[i]),
         .dn_active  (chain_active[i+1]),
         .dn_tok     (chain_tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpm_pkg::ST_IDLE: begin
            if (lookup_go) begin
               state_in = lpm_pkg::ST_SCAN;
            end
         end
         lpm_pkg::ST_SCAN: begin
            if (deliver) begin
               state_in = lpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         if (last_tok.found) begin
            rsp_hit_ff         <= 1'b1;
            rsp_match_index_ff <= last_tok.best_index;
            rsp_gateway_ff     <= last_tok.hop;
            rsp_out_port_ff    <= lpm_pkg::PORT_FIELD_BITS'(last_tok.port);
         end else begin
            rsp_hit_ff         <= 1'b0;
            rsp_match_index_ff <= '0;
            rsp_gateway_ff     <= '0;
            rsp_out_port_ff    <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_match_index_ff;
   assign rsp_gateway     = rsp_gateway_ff;
   assign rsp_out_port    = rsp_out_port_ff;

endmodule

// ----- src/lpm_checker.sv -----
module lpm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_action,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_hit,
   input logic [lpm_pkg::INDEX_BITS-1:0]        rsp_match_index,
   input logic [lpm_pkg::ADDR_BITS-1:0]         rsp_gateway,
   input logic [lpm_pkg::PORT_FIELD_BITS-1:0]   rsp_out_port
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_match_index) && $stable(rsp_gateway) && $stable(rsp_out_port))
      else $error("result word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_match_index == '0 && rsp_gateway == '0
         && rsp_out_port == '0)
      else $error("miss word carries nonzero fields");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == lpm_pkg::ACT_LOOKUP |=> !req_ready)
      else $error("request taken during a scan");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == lpm_pkg::ACT_WRITE && !rsp_valid
         |=> !rsp_valid)
      else $error("write produced a result word");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word without a scan");

endmodule

bind longest_prefix_match_route_lookup_top lpm_checker u_lpm_checker (.*);
